// ----- hw/rtl/sal_pkg.sv -----
// sal_pkg: shared types and codes for the service area list parser
// no dependencies; imported by sal_parser and service_area_list_parser_core

package sal_pkg;

    // partial list type codes, header bits 6..5
    localparam logic [1:0] LT_TAC_LIST  = 2'b00;
    localparam logic [1:0] LT_TAC_RUN   = 2'b01;
    localparam logic [1:0] LT_TAI_LIST  = 2'b10;
    localparam logic [1:0] LT_ALL_PLMN  = 2'b11;

    // header byte layout
    localparam int unsigned HDR_ALLOWED_BIT = 7;
    localparam int unsigned HDR_TYPE_HI     = 6;
    localparam int unsigned HDR_TYPE_LO     = 5;
    localparam int unsigned HDR_COUNT_HI    = 4;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_PLMN   = 3'b010,
        PH_TAC    = 3'b100
    } sal_phase_t;

    // one decoded area record
    typedef struct packed {
        logic [1:0]  list_type;
        logic        allowed_kind;
        logic [23:0] plmn_bytes;
        logic [23:0] area_code;
        logic [5:0]  run_length;
        logic [4:0]  element_index;
        logic        last_in_list;
        logic        truncated;
    } sal_record_t;

endpackage

// ----- hw/rtl/service_area_list_parser_core.sv -----
// Service area list parser: takes the value bytes of a service area list
// element one item per cycle unless the result side stalls, and gives one
// record per decoded area, plus an error record when the element ends
// inside a partial list. Each byte passes an input register, the byte-wide
// parser decode, and a result register, which drives m_valid; with m_ready
// held high a new byte is taken every cycle. The rate is set by the result
// register: a byte waits in the input register only while a record is held
// there and m_ready is low.
// Depends on sal_pkg and sal_parser.

module service_area_list_parser_core
    import sal_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_element,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_list_type,
    output logic        m_allowed_kind,
    output logic [23:0] m_plmn_bytes,
    output logic [23:0] m_area_code,
    output logic [5:0]  m_run_length,
    output logic [4:0]  m_element_index,
    output logic        m_last_in_list,
    output logic        m_truncated
);

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_eoe_reg;
    logic        m_valid_reg;
    sal_record_t out_rec_reg;

    logic        out_free;
    logic        advance;
    logic        rec_valid;
    sal_record_t rec;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data_byte;
            in_eoe_reg  <= s_end_of_element;
        end
    end

    // parser decode
    sal_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .data_byte      (in_data_reg),
        .end_of_element (in_eoe_reg),
        .rec_valid      (rec_valid),
        .rec            (rec)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && rec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && rec_valid) begin
            out_rec_reg <= rec;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_list_type     = out_rec_reg.list_type;
    assign m_allowed_kind  = out_rec_reg.allowed_kind;
    assign m_plmn_bytes    = out_rec_reg.plmn_bytes;
    assign m_area_code     = out_rec_reg.area_code;
    assign m_run_length    = out_rec_reg.run_length;
    assign m_element_index = out_rec_reg.element_index;
    assign m_last_in_list  = out_rec_reg.last_in_list;
    assign m_truncated     = out_rec_reg.truncated;

    // error records carry nothing else
    a_trunc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_run_length == 6'd0 && !m_last_in_list)
        else $error("truncated item with stray fields");

    // a real area always covers at least one code
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_truncated |-> m_run_length != 6'd0)
        else $error("area item with zero run length");

    // whole-plmn areas close their list and have no code
    a_all_plmn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_truncated && m_list_type == LT_ALL_PLMN
        |-> m_last_in_list && m_area_code == 24'd0)
        else $error("whole plmn item malformed");

    // a held input byte is not dropped while the result side stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input item lost while stalled");

endmodule

// ----- hw/rtl/sal_parser.sv -----
// sal_parser: byte-wide partial list state machine and record builder
// depends on sal_pkg for phase encoding, type codes and the record struct

module sal_parser
    import sal_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        end_of_element,
    output logic        rec_valid,
    output sal_record_t rec
);

    sal_phase_t  phase_reg, phase_next;
    logic [1:0]  byte_position_reg, byte_position_next;
    logic [4:0]  elements_left_reg, elements_left_next;
    logic [1:0]  current_type_reg, current_type_next;
    logic        current_allowed_reg, current_allowed_next;
    logic [23:0] plmn_shift_reg, plmn_shift_next;
    logic [23:0] code_shift_reg, code_shift_next;
    logic [4:0]  index_count_reg, index_count_next;

    logic [23:0] plmn_shifted;
    logic [23:0] code_shifted;
    logic        pos_done;
    logic        emit;
    logic        last;

    assign plmn_shifted = {plmn_shift_reg[15:0], data_byte};
    assign code_shifted = {code_shift_reg[15:0], data_byte};
    assign pos_done     = (byte_position_reg == 2'd2);

    // next state and record for the byte at the input
    always_comb begin
        phase_next           = phase_reg;
        byte_position_next   = byte_position_reg;
        elements_left_next   = elements_left_reg;
        current_type_next    = current_type_reg;
        current_allowed_next = current_allowed_reg;
        plmn_shift_next      = plmn_shift_reg;
        code_shift_next      = code_shift_reg;
        index_count_next     = index_count_reg;
        emit                 = 1'b0;
        last                 = 1'b0;
        rec                  = '0;
        rec.run_length       = 6'd1;

        unique case (phase_reg)
            PH_HEADER: begin
                elements_left_next   = data_byte[HDR_COUNT_HI:0];
                current_type_next    = data_byte[HDR_TYPE_HI:HDR_TYPE_LO];
                current_allowed_next = data_byte[HDR_ALLOWED_BIT];
                index_count_next     = '0;
                byte_position_next   = '0;
                plmn_shift_next      = '0;
                code_shift_next      = '0;
                phase_next           = PH_PLMN;
            end
            PH_PLMN: begin
                plmn_shift_next = plmn_shifted;
                if (pos_done) begin
                    byte_position_next = '0;
                    if (current_type_reg == LT_ALL_PLMN) begin
                        emit              = 1'b1;
                        last              = 1'b1;
                        rec.list_type     = LT_ALL_PLMN;
                        rec.allowed_kind  = current_allowed_reg;
                        rec.plmn_bytes    = plmn_shifted;
                        rec.area_code     = '0;
                        rec.element_index = '0;
                        phase_next        = PH_HEADER;
                    end else begin
                        phase_next = PH_TAC;
                    end
                end else begin
                    byte_position_next = byte_position_reg + 2'd1;
                end
            end
            PH_TAC: begin
                code_shift_next = code_shifted;
                if (pos_done) begin
                    byte_position_next = '0;
                    emit               = 1'b1;
                    rec.list_type      = current_type_reg;
                    rec.allowed_kind   = current_allowed_reg;
                    rec.plmn_bytes     = plmn_shift_reg;
                    rec.area_code      = code_shifted;
                    rec.element_index  = index_count_reg;
                    // a consecutive run is one record covering count+1 codes
                    if (current_type_reg == LT_TAC_RUN) begin
                        rec.run_length = {1'b0, elements_left_reg} + 6'd1;
                        last           = 1'b1;
                    end else begin
                        last = (elements_left_reg == 5'd0);
                    end
                    code_shift_next = '0;
                    if (last) begin
                        phase_next = PH_HEADER;
                    end else begin
                        elements_left_next = elements_left_reg - 5'd1;
                        index_count_next   = index_count_reg + 5'd1;
                        phase_next = (current_type_reg == LT_TAI_LIST) ? PH_PLMN : PH_TAC;
                    end
                end else begin
                    byte_position_next = byte_position_reg + 2'd1;
                end
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        rec.last_in_list = last;

        // element ended inside a partial list: error record, start over
        if (end_of_element && !(emit && last)) begin
            phase_next           = PH_HEADER;
            byte_position_next   = '0;
            elements_left_next   = '0;
            current_type_next    = '0;
            current_allowed_next = 1'b0;
            plmn_shift_next      = '0;
            code_shift_next      = '0;
            index_count_next     = '0;
            rec                  = '0;
            rec.truncated        = 1'b1;
        end
    end

    assign rec_valid = emit || end_of_element;

    // parser state, advanced once per consumed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_HEADER;
            byte_position_reg   <= '0;
            elements_left_reg   <= '0;
            current_type_reg    <= '0;
            current_allowed_reg <= 1'b0;
            plmn_shift_reg      <= '0;
            code_shift_reg      <= '0;
            index_count_reg     <= '0;
        end else if (step) begin
            phase_reg           <= phase_next;
            byte_position_reg   <= byte_position_next;
            elements_left_reg   <= elements_left_next;
            current_type_reg    <= current_type_next;
            current_allowed_reg <= current_allowed_next;
            plmn_shift_reg      <= plmn_shift_next;
            code_shift_reg      <= code_shift_next;
            index_count_reg     <= index_count_next;
        end
    end

    // a byte count of three never occurs
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_position_reg != 2'd3)
        else $error("byte position out of range");

    // header phase always starts with a cleared byte position
    a_header_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEADER |-> byte_position_reg == 2'd0)
        else $error("byte position not cleared at header");

    // an index never runs past the header count
    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TAC && current_type_reg == LT_TAC_LIST
        |-> ({1'b0, index_count_reg} + {1'b0, elements_left_reg}) <= 6'd31)
        else $error("element index beyond list count");

endmodule
